### design/assert_macros.svh
// Assertion helpers for the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/mtvb_pkg.sv
`default_nettype none

package mtvb_pkg;

    localparam int NUM_SLOTS   = 8;
    localparam int SLOT_IDX_W  = 3;
    localparam int NUM_LANES   = NUM_SLOTS + 1;
    localparam int CFG_INDEX_W = 4;
    localparam int WEIGHT_W    = 16;
    localparam int FACTOR_W    = 16;
    localparam int VALUE_W     = 32;
    localparam int TOTAL_W     = 19;
    localparam int NUM_W       = 32;
    localparam int DIV_CNT_W   = 4;
    localparam int PROD_W      = 48;
    localparam int ACC_W       = 52;
    localparam int FRAC_SHIFT  = 15;
    localparam int SHIFT_W     = ACC_W - FRAC_SHIFT;
    localparam int PIPE_LAT    = 6;

    localparam logic [SLOT_IDX_W-1:0] LAST_SLOT = SLOT_IDX_W'(NUM_SLOTS - 1);
    localparam logic [DIV_CNT_W-1:0]  LAST_STEP = '1;
    localparam logic [TOTAL_W-1:0]    ONE_Q12   = TOTAL_W'(4096);
    localparam logic [ACC_W-1:0]      ROUND_BIAS = ACC_W'(16384);
    localparam logic [VALUE_W-1:0]    SAT_MAX   = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0]    SAT_MIN   = 32'h8000_0000;

    typedef logic [NUM_SLOTS-1:0][WEIGHT_W-1:0] weight_vec_t;
    typedef logic [NUM_SLOTS-1:0][FACTOR_W-1:0] tgt_factor_vec_t;
    typedef logic [NUM_LANES-1:0][FACTOR_W-1:0] factor_vec_t;
    typedef logic [NUM_LANES-1:0][VALUE_W-1:0]  value_vec_t;

    typedef struct packed {
        logic                   en;
        logic [CFG_INDEX_W-1:0] index;
        logic [WEIGHT_W-1:0]    data;
    } cfg_wr_t;

    typedef struct packed {
        logic busy;
        logic cfg_ready;
    } fu_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_NORM,
        ST_PREP,
        ST_DIV,
        ST_STORE
    } fsm_state_t;

endpackage

`default_nettype wire

### design/morph_target_vertex_blend.sv
`default_nettype none

// Morph target vertex blend. One item is one attribute component of the
// base mesh and of eight morph targets (signed Q16.16); its result is the
// weighted blend, rounded half up and saturated to signed Q16.16. An item
// is taken on any edge with start high and busy low, one per cycle, and
// its result appears on blended_value with done high for exactly one cycle,
// after passing the product, adder-tree, accumulator and output registers;
// the receiver cannot stall, so the result must be captured in that cycle.
// Writing a weight register (index 0..7 on the cfg channel) rederives the
// nine blend factors: busy is held high and cfg_ready low while the weights
// are totalled and normalized, then while each target with a nonzero weight
// is divided (one restoring divider, one quotient bit a cycle) and each
// other target has its factor cleared. Write weights only while no item is
// in flight; writes to indexes beyond the list are taken and dropped.
module morph_target_vertex_blend
    import mtvb_pkg::*;
#(
    parameter int MAX_TARGETS = 8
)(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    output logic                        done,
    input  wire logic [VALUE_W-1:0]     base_value,
    input  wire logic [VALUE_W-1:0]     target_value_0,
    input  wire logic [VALUE_W-1:0]     target_value_1,
    input  wire logic [VALUE_W-1:0]     target_value_2,
    input  wire logic [VALUE_W-1:0]     target_value_3,
    input  wire logic [VALUE_W-1:0]     target_value_4,
    input  wire logic [VALUE_W-1:0]     target_value_5,
    input  wire logic [VALUE_W-1:0]     target_value_6,
    input  wire logic [VALUE_W-1:0]     target_value_7,
    output logic [VALUE_W-1:0]          blended_value,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [WEIGHT_W-1:0]    cfg_data
);

    `include "assert_macros.svh"

    cfg_wr_t     cfg_wr;
    fu_status_t  fu_status;
    factor_vec_t factors;
    value_vec_t  values;
    logic        item_take;

    // Register write handshake; the factor unit decodes the index
    assign cfg_wr.en    = cfg_valid && cfg_ready;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    assign busy      = fu_status.busy;
    assign cfg_ready = fu_status.cfg_ready;
    assign item_take = start && !busy;

    // Lane 8 carries the base, lanes 0..7 the targets, matching the factors
    assign values = {base_value,
                     target_value_7, target_value_6, target_value_5, target_value_4,
                     target_value_3, target_value_2, target_value_1, target_value_0};

    mtvb_factor_unit #(
        .MAX_TARGETS (MAX_TARGETS)
    ) u_factor (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_wr  (cfg_wr),
        .status  (fu_status),
        .factors (factors)
    );

    mtvb_blend_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item_take),
        .values    (values),
        .factors   (factors),
        .out_valid (done),
        .out_value (blended_value)
    );

    // Every accepted item yields its result
    `ASSERT_SAME(a_item_latency, item_take, ##6 done, "accepted item lost its result")
    // A result never appears without an item accepted before it
    `ASSERT_SAME(a_no_phantom, done, $past(item_take, 6), "result without an item")
    // An in-range weight write starts factor derivation
    `ASSERT_NEXT(a_write_derives, cfg_wr.en && (32'(cfg_index) < NUM_SLOTS), busy,
                 "weight write did not start derivation")

endmodule

`default_nettype wire

### design/mtvb_factor_unit.sv
`default_nettype none

// Weight registers and blend factor derivation: serial total, then one
// restoring divide (one quotient bit per cycle) for each active target.
module mtvb_factor_unit
    import mtvb_pkg::*;
#(
    parameter int MAX_TARGETS = 8
)(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cfg_wr_t    cfg_wr,
    output fu_status_t      status,
    output factor_vec_t     factors
);

    fsm_state_t state_reg;
    fsm_state_t state_next;

    weight_vec_t           weight_reg;
    tgt_factor_vec_t       tgt_factor_reg;
    logic [FACTOR_W-1:0]   base_factor_reg;
    logic [SLOT_IDX_W-1:0] idx_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [TOTAL_W-1:0]    total_reg;
    logic [TOTAL_W-1:0]    div_reg;
    logic [TOTAL_W-1:0]    rem_reg;
    logic [FACTOR_W-1:0]   quo_reg;

    logic                  wr_hit;
    logic [WEIGHT_W-1:0]   cur_weight;
    logic                  slot_active;
    logic [NUM_W-1:0]      num;
    logic [TOTAL_W:0]      trial;
    logic                  fits;

    assign wr_hit      = cfg_wr.en && (32'(cfg_wr.index) < NUM_SLOTS);
    assign cur_weight  = weight_reg[idx_reg];
    assign slot_active = (32'(idx_reg) < MAX_TARGETS) && (cur_weight != '0);
    // Rounded dividend: w * 2^15 + div / 2
    assign num   = {1'b0, cur_weight, 15'b0} + NUM_W'(div_reg[TOTAL_W-1:1]);
    assign trial = {rem_reg, quo_reg[FACTOR_W-1]};
    assign fits  = trial >= {1'b0, div_reg};

    assign factors = {base_factor_reg, tgt_factor_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  state_next = wr_hit ? ST_SUM : ST_IDLE;
            ST_SUM:   state_next = (idx_reg == LAST_SLOT) ? ST_NORM : ST_SUM;
            ST_NORM:  state_next = ST_PREP;
            ST_PREP:
            begin
                if (slot_active)
                    state_next = ST_DIV;
                else
                    state_next = (idx_reg == LAST_SLOT) ? ST_IDLE : ST_PREP;
            end
            ST_DIV:   state_next = (cnt_reg == LAST_STEP) ? ST_STORE : ST_DIV;
            ST_STORE: state_next = (idx_reg == LAST_SLOT) ? ST_IDLE : ST_PREP;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        status.busy      = (state_reg != ST_IDLE);
        status.cfg_ready = (state_reg == ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            weight_reg      <= '0;
            tgt_factor_reg  <= '0;
            base_factor_reg <= '0;
            idx_reg         <= '0;
            cnt_reg         <= '0;
            total_reg       <= '0;
            div_reg         <= '0;
            rem_reg         <= '0;
            quo_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (wr_hit)
                    begin
                        weight_reg[cfg_wr.index[SLOT_IDX_W-1:0]] <= cfg_wr.data;
                        idx_reg   <= '0;
                        total_reg <= '0;
                    end
                end
                ST_SUM:
                begin
                    if (slot_active)
                        total_reg <= total_reg + TOTAL_W'(cur_weight);
                    idx_reg <= idx_reg + 1'b1;
                end
                ST_NORM:
                begin
                    // Total below one: base takes the remainder, total becomes one
                    if (total_reg < ONE_Q12)
                    begin
                        base_factor_reg <= FACTOR_W'((ONE_Q12 - total_reg) << 3);
                        div_reg         <= ONE_Q12;
                    end
                    else
                    begin
                        base_factor_reg <= '0;
                        div_reg         <= total_reg;
                    end
                end
                ST_PREP:
                begin
                    if (slot_active)
                    begin
                        rem_reg <= TOTAL_W'(num[NUM_W-1:FACTOR_W]);
                        quo_reg <= num[FACTOR_W-1:0];
                        cnt_reg <= '0;
                    end
                    else
                    begin
                        tgt_factor_reg[idx_reg] <= '0;
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_DIV:
                begin
                    rem_reg <= fits ? TOTAL_W'(trial - {1'b0, div_reg})
                                    : trial[TOTAL_W-1:0];
                    quo_reg <= {quo_reg[FACTOR_W-2:0], fits};
                    cnt_reg <= cnt_reg + 1'b1;
                end
                ST_STORE:
                begin
                    tgt_factor_reg[idx_reg] <= quo_reg;
                    idx_reg <= idx_reg + 1'b1;
                end
                default:
                begin
                    idx_reg <= '0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### design/mtvb_blend_pipe.sv
`default_nettype none

// Nine-lane multiply and registered adder tree, then round and saturate.
module mtvb_blend_pipe
    import mtvb_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire value_vec_t         values,
    input  wire factor_vec_t        factors,
    output logic                    out_valid,
    output logic [VALUE_W-1:0]      out_value
);

    logic [PIPE_LAT-2:0]                  valid_reg;
    logic [NUM_LANES-1:0][PROD_W-1:0]     prod_reg;
    logic [NUM_LANES-1:0][PROD_W-1:0]     prod_next;
    logic [4:0][ACC_W-1:0]                s2_reg;
    logic [2:0][ACC_W-1:0]                s3_reg;
    logic [1:0][ACC_W-1:0]                s4_reg;
    logic [ACC_W-1:0]                     acc_reg;
    logic                                 done_reg;
    logic [VALUE_W-1:0]                   value_reg;
    logic [VALUE_W-1:0]                   value_next;
    logic [SHIFT_W-1:0]                   shifted;
    logic [SHIFT_W-VALUE_W:0]             upper;

    function automatic logic [ACC_W-1:0] sext_prod(input logic [PROD_W-1:0] p);
        sext_prod = {{(ACC_W-PROD_W){p[PROD_W-1]}}, p};
    endfunction

    always_comb
    begin
        for (int k = 0; k < NUM_LANES; k++)
        begin
            prod_next[k] = PROD_W'($signed(values[k]) * $signed({1'b0, factors[k]}));
        end
    end

    // Floor of the biased sum over 2^15, then clamp to 32 bits
    assign shifted = acc_reg[ACC_W-1:FRAC_SHIFT];
    assign upper   = shifted[SHIFT_W-1:VALUE_W-1];

    always_comb
    begin
        if ((&upper) || !(|upper))
            value_next = shifted[VALUE_W-1:0];
        else
            value_next = shifted[SHIFT_W-1] ? SAT_MIN : SAT_MAX;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= {valid_reg[PIPE_LAT-3:0], in_valid};
            done_reg  <= valid_reg[PIPE_LAT-2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
            prod_reg <= prod_next;
        if (valid_reg[0])
        begin
            s2_reg[0] <= sext_prod(prod_reg[0]) + sext_prod(prod_reg[1]);
            s2_reg[1] <= sext_prod(prod_reg[2]) + sext_prod(prod_reg[3]);
            s2_reg[2] <= sext_prod(prod_reg[4]) + sext_prod(prod_reg[5]);
            s2_reg[3] <= sext_prod(prod_reg[6]) + sext_prod(prod_reg[7]);
            s2_reg[4] <= sext_prod(prod_reg[8]);
        end
        if (valid_reg[1])
        begin
            s3_reg[0] <= s2_reg[0] + s2_reg[1];
            s3_reg[1] <= s2_reg[2] + s2_reg[3];
            s3_reg[2] <= s2_reg[4];
        end
        if (valid_reg[2])
        begin
            s4_reg[0] <= s3_reg[0] + s3_reg[1];
            s4_reg[1] <= s3_reg[2];
        end
        if (valid_reg[3])
            acc_reg <= s4_reg[0] + s4_reg[1] + ROUND_BIAS;
        if (valid_reg[4])
            value_reg <= value_next;
    end

    assign out_valid = done_reg;
    assign out_value = value_reg;

endmodule

`default_nettype wire

### tb/sv/morph_target_vertex_blend_tb.sv
`default_nettype none

// Testbench for the morph target vertex blend.
// One process sends items and writes weights. A second process checks every
// done strobe against the oldest predicted blend. A third process ends the
// run when nothing moves for too long.
module morph_target_vertex_blend_tb;
    import mtvb_pkg::*;

    localparam int BLEND_TARGETS = 8;
    localparam int BASE_LANE     = NUM_SLOTS;
    localparam int UNITY_Q12     = 4096;
    localparam int UNITY_Q15     = 32768;
    localparam int RANDOM_ITEMS  = 1830;
    localparam int REPORT_LIMIT  = 10;
    // Longest quiet stretch in a correct run: the longest sender gap, the
    // pause before a weight write, factor derivation and the pipeline. Allow
    // several times that.
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_LIMIT   = 200;

    localparam longint Q16_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint Q16_MIN = -64'sh0000_0000_8000_0000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TARGET_WEIGHT_0,
        REG_TARGET_WEIGHT_1,
        REG_TARGET_WEIGHT_2,
        REG_TARGET_WEIGHT_3,
        REG_TARGET_WEIGHT_4,
        REG_TARGET_WEIGHT_5,
        REG_TARGET_WEIGHT_6,
        REG_TARGET_WEIGHT_7,
        REG_UNUSED_8,
        REG_UNUSED_15 = 15
    } weight_reg_e;

    // Shapes of a weight setting for one random phase.
    typedef enum int {
        WP_ZERO,     // every target off, base passes through
        WP_SMALL,    // total below one, base keeps the rest
        WP_FULL,     // any 16-bit weight, some targets off
        WP_EXTREME   // only 0, 1, 1.0 and the largest weight
    } weight_profile_e;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic                   done;
    value_vec_t             item_bus = '0;
    logic [VALUE_W-1:0]     blended_value;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [WEIGHT_W-1:0]    cfg_data = '0;

    // Predictor state: weights as written and the factors derived from them.
    weight_vec_t weight_regs   = '0;
    factor_vec_t blend_factors = '0;

    logic [VALUE_W-1:0] blended_q[$];

    int items_sent      = 0;
    int results_checked = 0;
    int weight_writes   = 0;
    int mismatches      = 0;
    int quiet_cycles    = 0;

    morph_target_vertex_blend #(
        .MAX_TARGETS(BLEND_TARGETS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .done          (done),
        .base_value    (item_bus[BASE_LANE]),
        .target_value_0(item_bus[0]),
        .target_value_1(item_bus[1]),
        .target_value_2(item_bus[2]),
        .target_value_3(item_bus[3]),
        .target_value_4(item_bus[4]),
        .target_value_5(item_bus[5]),
        .target_value_6(item_bus[6]),
        .target_value_7(item_bus[7]),
        .blended_value (blended_value),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Rederive the nine factors from the current weights. Only targets with
    // a nonzero weight count; a total below one is topped up by the base.
    function automatic void derive_blend_factors();
        int unsigned      total;
        longint unsigned  scaled;
        total = 0;
        for (int k = 0; k < NUM_SLOTS; k++)
            if (k < BLEND_TARGETS && weight_regs[k] != 0)
                total += weight_regs[k];
        if (total < UNITY_Q12)
        begin
            blend_factors[BASE_LANE] = FACTOR_W'((UNITY_Q12 - total) << 3);
            total = UNITY_Q12;
        end
        else
            blend_factors[BASE_LANE] = '0;
        for (int k = 0; k < NUM_SLOTS; k++)
        begin
            if (k < BLEND_TARGETS && weight_regs[k] != 0)
            begin
                // Round half up; exact when the total was topped up to one.
                scaled = longint'(weight_regs[k]) * UNITY_Q15 + (total >> 1);
                blend_factors[k] = FACTOR_W'(scaled / total);
            end
            else
                blend_factors[k] = '0;
        end
    endfunction

    // Weighted sum over all nine lanes, rounded half toward +inf, saturated.
    function automatic logic [VALUE_W-1:0] predict_blend(input value_vec_t vals);
        longint acc;
        longint rounded;
        acc = 0;
        for (int k = 0; k < NUM_LANES; k++)
            acc += longint'($signed(vals[k])) * longint'(blend_factors[k]);
        rounded = (acc + longint'(16384)) >>> 15;
        if (rounded > Q16_MAX)
            return SAT_MAX;
        if (rounded < Q16_MIN)
            return SAT_MIN;
        return rounded[VALUE_W-1:0];
    endfunction

    function automatic logic [VALUE_W-1:0] rand_component();
        case ($urandom_range(0, 9))
            0:       return SAT_MAX;
            1:       return SAT_MIN;
            2:       return VALUE_W'($urandom_range(0, 131071)) - 32'd65536;
            default: return $urandom();
        endcase
    endfunction

    function automatic void note_mismatch(input string what, input logic [VALUE_W-1:0] want,
                                          input logic [VALUE_W-1:0] got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("mismatch (%s): expected %h, got %h", what, want, got);
    endfunction

    // Present one item and hold it until the block takes it. Leave start
    // high when the next item follows at once, drop it for a gap.
    task automatic send_item(input value_vec_t vals, input int gap);
        item_bus <= vals;
        start    <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        blended_q.insert(blended_q.size(), predict_blend(vals));
        items_sent++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Write one weight register once the block is idle: no blend pending and
    // the pipeline flushed. The block holds busy while it rederives.
    task automatic write_weight(input logic [CFG_INDEX_W-1:0] index,
                                input logic [WEIGHT_W-1:0] data);
        start <= 1'b0;
        while (blended_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 2) @(posedge clk);
        cfg_index <= index;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (index < NUM_SLOTS)
        begin
            weight_regs[index[SLOT_IDX_W-1:0]] = data;
            derive_blend_factors();
        end
        weight_writes++;
    endtask

    // Out of reset all factors are zero, so every blend is zero.
    task automatic test_reset_output();
        send_item({NUM_LANES{SAT_MAX}}, 0);
        send_item({NUM_LANES{SAT_MIN}}, 1);
    endtask

    // One target at exactly one, a target turned back off, and a single
    // target at the largest weight (normalized down to one).
    task automatic test_single_target();
        value_vec_t v;
        for (int k = 0; k < NUM_LANES; k++)
            v[k] = rand_component();
        write_weight(REG_TARGET_WEIGHT_0, 16'h1000);
        v[0] = SAT_MAX;
        send_item(v, 0);
        v[0] = SAT_MIN;
        send_item(v, 2);
        write_weight(REG_TARGET_WEIGHT_0, '0);
        v[BASE_LANE] = 32'h1234_5678;
        send_item(v, 0);
        write_weight(REG_TARGET_WEIGHT_7, 16'hFFFF);
        v[7] = SAT_MIN;
        send_item(v, 1);
        write_weight(REG_TARGET_WEIGHT_7, '0);
    endtask

    // Half on the base and half on target 3: odd base values land exactly
    // on a half and must round toward +inf on both signs.
    task automatic test_rounding_ties();
        value_vec_t v;
        v = '0;
        write_weight(REG_TARGET_WEIGHT_3, 16'h0800);
        v[BASE_LANE] = 32'sd1;
        send_item(v, 0);
        v[BASE_LANE] = -32'sd1;
        send_item(v, 0);
        v[BASE_LANE] = 32'sd3;
        send_item(v, 3);
        v[BASE_LANE] = -32'sd3;
        send_item(v, 0);
        write_weight(REG_TARGET_WEIGHT_3, '0);
    endtask

    // Three equal weights give factors summing just above one, so full-scale
    // values overflow and must clamp at both ends.
    task automatic test_saturation();
        write_weight(REG_TARGET_WEIGHT_0, 16'h3000);
        write_weight(REG_TARGET_WEIGHT_1, 16'h3000);
        write_weight(REG_TARGET_WEIGHT_2, 16'h3000);
        send_item({NUM_LANES{SAT_MAX}}, 0);
        send_item({NUM_LANES{SAT_MIN}}, 0);
        write_weight(REG_TARGET_WEIGHT_0, '0);
        write_weight(REG_TARGET_WEIGHT_1, '0);
        write_weight(REG_TARGET_WEIGHT_2, '0);
    endtask

    // Writes past the register list must leave the factors alone; then load
    // every target at the largest weight for the largest total.
    task automatic test_ignored_index();
        value_vec_t v;
        for (int k = 0; k < NUM_LANES; k++)
            v[k] = rand_component();
        write_weight(REG_UNUSED_8, 16'hFFFF);
        write_weight(REG_UNUSED_15, 16'h1234);
        send_item(v, 0);
        for (int k = 0; k < NUM_SLOTS; k++)
            write_weight(CFG_INDEX_W'(k), 16'hFFFF);
        send_item({NUM_LANES{SAT_MAX}}, 0);
        send_item({NUM_LANES{SAT_MIN}}, 1);
    endtask

    // Random phases: a fresh weight setting, then a burst of random items
    // with random gaps, or none at all in some phases.
    task automatic test_random_blend();
        value_vec_t      v;
        weight_profile_e profile;
        logic [WEIGHT_W-1:0] w;
        bit              no_idle;
        int              phase_items;
        int              gap;
        int              random_sent;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            profile = weight_profile_e'($urandom_range(0, 3));
            for (int k = 0; k < NUM_SLOTS; k++)
            begin
                case (profile)
                    WP_ZERO:  w = '0;
                    WP_SMALL: w = ($urandom_range(0, 3) == 0) ? '0
                                  : WEIGHT_W'($urandom_range(1, 511));
                    WP_FULL:  w = ($urandom_range(0, 2) == 0) ? '0 : WEIGHT_W'($urandom());
                    default:
                        case ($urandom_range(0, 3))
                            0:       w = '0;
                            1:       w = 16'h0001;
                            2:       w = 16'h1000;
                            default: w = 16'hFFFF;
                        endcase
                endcase
                write_weight(CFG_INDEX_W'(k), w);
            end
            if ($urandom_range(0, 3) == 0)
                write_weight(CFG_INDEX_W'($urandom_range(NUM_SLOTS, (1 << CFG_INDEX_W) - 1)),
                             WEIGHT_W'($urandom()));
            no_idle     = ($urandom_range(0, 2) == 0);
            phase_items = $urandom_range(60, 140);
            // Trim the last phase to the item budget.
            if (phase_items > RANDOM_ITEMS - random_sent)
                phase_items = RANDOM_ITEMS - random_sent;
            for (int i = 0; i < phase_items; i++)
            begin
                for (int k = 0; k < NUM_LANES; k++)
                    v[k] = rand_component();
                // Mostly back to back, some short gaps, a few long ones.
                gap = $urandom_range(0, 99);
                if (no_idle || gap < 60)
                    gap = 0;
                else if (gap < 93)
                    gap = $urandom_range(1, 3);
                else
                    gap = $urandom_range(10, 40);
                send_item(v, gap);
            end
            random_sent += phase_items;
        end
    endtask

    // Check each done strobe against the oldest predicted blend.
    always @(posedge clk)
    begin
        logic [VALUE_W-1:0] want;
        if (rst_n && done)
        begin
            if (blended_q.size() == 0)
                note_mismatch("unexpected result", 'x, blended_value);
            else
            begin
                want = blended_q.pop_front();
                if (blended_value !== want)
                    note_mismatch("blended_value", want, blended_value);
                results_checked++;
            end
        end
    end

    // End the run when no item, result or weight write moves for too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no progress for %0d cycles", STALL_LIMIT);
                $display("morph_target_vertex_blend_tb: errors");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_output();
        test_single_target();
        test_rounding_ties();
        test_saturation();
        test_ignored_index();
        test_random_blend();

        // Drain: wait out every pending blend, then the pipeline depth.
        start <= 1'b0;
        for (int c = 0; c < DRAIN_LIMIT && blended_q.size() != 0; c++)
            @(posedge clk);
        repeat (PIPE_LAT + 4) @(posedge clk);
        while (blended_q.size() != 0)
            note_mismatch("missing result", blended_q.pop_front(), 'x);

        $display("covered %0d blended items over %0d weight writes, %0d results compared",
                 items_sent, weight_writes, results_checked);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("morph_target_vertex_blend_tb: clean");
        else
            $display("morph_target_vertex_blend_tb: errors");
        $finish;
    end

endmodule

`default_nettype wire
